FILE: rtl/socket_slot_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Socket slot table assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SOCKET_SLOT_TABLE_UNIT_MACROS_SVH
`define SOCKET_SLOT_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sst: same-cycle check failed");
`define SST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sst: next-cycle check failed");
`else
`define SST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SST_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// Socket slot table package
// Field widths, operation and status codes, and shared word types.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned PORT_BITS   = 16;
  localparam int unsigned FUNC_BITS   = 3;
  localparam int unsigned IDX_BITS    = 4;
  localparam int unsigned SLOT_BITS   = 4;
  localparam int unsigned SLOTS_DFLT  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [PORT_BITS-1:0] EPH_FIRST = 16'hC000;
  localparam logic [PORT_BITS-1:0] EPH_NONE  = 16'hFFFF;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_FIND   = 3'd0,
    FN_GET    = 3'd1,
    FN_REMOVE = 3'd2,
    FN_ADD    = 3'd3,
    FN_ALLOC  = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    OP_FIND,
    OP_GET,
    OP_REMOVE,
    OP_ADD,
    OP_ALLOC,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOPORT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_FIND,
    BK_ADD,
    BK_MAP,
    BK_PICK,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    op_e                  op;
    logic [ADDR_BITS-1:0] addr;
    logic [PORT_BITS-1:0] port;
    logic [IDX_BITS-1:0]  idx;
    logic                 idx_ok;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    logic [SLOT_BITS-1:0] slot;
    logic [ADDR_BITS-1:0] addr;
    logic [PORT_BITS-1:0] port;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam res_t RES_MISS = '{status: ST_MISS, slot: '0, addr: '0, port: '0};
  localparam res_t RES_FULL = '{status: ST_FULL, slot: '0, addr: '0, port: '0};

endpackage

FILE: rtl/sst_if.sv
// ----------------------------------------------------------------------------
// Socket slot table channels
// Request and response valid/ready channels with their word payloads.
// ----------------------------------------------------------------------------
interface sst_req_if;
  logic                          valid;
  logic                          ready;
  logic [sst_pkg::FUNC_BITS-1:0] func;
  logic [sst_pkg::ADDR_BITS-1:0] local_addr;
  logic [sst_pkg::PORT_BITS-1:0] local_port;
  logic [sst_pkg::IDX_BITS-1:0]  slot_index;

  modport source (output valid, func, local_addr, local_port, slot_index, input ready);
  modport sink   (input valid, func, local_addr, local_port, slot_index, output ready);
endinterface

interface sst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [sst_pkg::SLOT_BITS-1:0] slot_out;
  logic [sst_pkg::ADDR_BITS-1:0] addr_out;
  logic [sst_pkg::PORT_BITS-1:0] port_out;

  modport source (output valid, status, slot_out, addr_out, port_out, input ready);
  modport sink   (input valid, status, slot_out, addr_out, port_out, output ready);
endinterface

FILE: rtl/socket_slot_table_unit.sv
// ----------------------------------------------------------------------------
// Socket slot table unit
// Get/remove read the indexed slot, find/add scan the slots in order and
// allocate maps used ephemeral ports, then picks one; one slot RAM read per
// cycle. One word in the back end at a time: the next word leaves the queue
// only after the last is emitted; front queue takes two words while busy.
// Reset clears all valid bits at once; no clearing pass, ready after reset.
// ----------------------------------------------------------------------------
`include "socket_slot_table_unit_macros.svh"

module socket_slot_table_unit #(
  parameter int unsigned SLOTS  = sst_pkg::SLOTS_DFLT,
  parameter int unsigned QDEPTH = sst_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sst_req_if.sink   req_i,
  sst_rsp_if.source rsp_o
);
  import sst_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head_cmd;
  q_stat_t q_stat;
  logic    push;
  logic    cmd_pop;
  logic    rsp_full;
  logic    rsp_zero;

  sst_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  sst_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (cmd_pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  sst_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_avail_i (!q_stat.empty),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

  assign rsp_full = rsp_o.valid && (rsp_o.status == ST_FULL);
  assign rsp_zero = (rsp_o.slot_out == '0) && (rsp_o.addr_out == '0) &&
                    (rsp_o.port_out == '0);

  `SST_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, cmd_pop, !q_stat.empty)
  `SST_ASSERT_NXT(a_push_fills, clk_i, rst_ni, push && !cmd_pop, !q_stat.empty)
  `SST_ASSERT_IMP(a_full_zero, clk_i, rst_ni, rsp_full, rsp_zero)

endmodule

FILE: rtl/sst_ram.sv
// ----------------------------------------------------------------------------
// Socket slot table RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sst_front.sv
// ----------------------------------------------------------------------------
// Socket slot table front end
// Takes request words, decodes the operation and checks the slot index.
// ----------------------------------------------------------------------------
module sst_front #(
  parameter int unsigned SLOTS = sst_pkg::SLOTS_DFLT
) (
  sst_req_if.sink          req_i,
  input  sst_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output sst_pkg::cmd_t    cmd_o
);
  import sst_pkg::*;

  assign req_i.ready = !q_stat_i.full;
  assign push_o      = req_i.valid && !q_stat_i.full;

  always_comb begin
    cmd_o.addr   = req_i.local_addr;
    cmd_o.port   = req_i.local_port;
    cmd_o.idx    = req_i.slot_index;
    cmd_o.idx_ok = 32'(req_i.slot_index) < SLOTS;
    case (func_e'(req_i.func))
      FN_FIND:   cmd_o.op = OP_FIND;
      FN_GET:    cmd_o.op = OP_GET;
      FN_REMOVE: cmd_o.op = OP_REMOVE;
      FN_ADD:    cmd_o.op = OP_ADD;
      FN_ALLOC:  cmd_o.op = OP_ALLOC;
      default:   cmd_o.op = OP_BAD;
    endcase
  end

endmodule

FILE: rtl/sst_fifo.sv
// ----------------------------------------------------------------------------
// Socket slot table command queue
// Short FIFO of decoded commands between front end and back end.
// ----------------------------------------------------------------------------
module sst_fifo #(
  parameter int unsigned DEPTH = sst_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sst_pkg::cmd_t     cmd_i,
  input  logic              pop_i,
  output sst_pkg::cmd_t     cmd_o,
  output sst_pkg::q_stat_t  stat_o
);
  import sst_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign stat_o.full  = cnt_q == NW'(DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/sst_back.sv
// ----------------------------------------------------------------------------
// Socket slot table back end
// Sequencer over the slot RAM and valid bits; one slot checked per cycle.
// ----------------------------------------------------------------------------
module sst_back #(
  parameter int unsigned SLOTS = sst_pkg::SLOTS_DFLT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sst_pkg::cmd_t cmd_i,
  input  logic          cmd_avail_i,
  output logic          cmd_pop_o,
  sst_rsp_if.source     rsp_o
);
  import sst_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = ADDR_BITS + PORT_BITS;
  localparam logic [IW-1:0]        LAST = IW'(SLOTS - 1);
  localparam logic [PORT_BITS-1:0] SPAN = PORT_BITS'(SLOTS);

  bk_state_e            state_q, state_d;
  cmd_t                 cmd_q, cmd_d;
  logic [IW-1:0]        chk_q, chk_d, chk_nx;
  logic [CW-1:0]        pick_q, pick_d;
  logic [SLOTS:0]       used_q, used_d;
  logic [SLOTS-1:0]     valid_q, valid_d;
  res_t                 res_q, res_d;
  res_t                 out_q, out_d;
  logic                 out_vld_q, out_vld_d;

  logic                 ram_we;
  logic [IW-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [PORT_BITS-1:0] rd_port;
  logic [PORT_BITS-1:0] eph_off;
  logic [PORT_BITS-1:0] cand_port;
  logic                 slot_live, port_hit, addr_hit, eph_in, out_free;

  sst_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (chk_q),
    .wdata_i ({cmd_q.addr, cmd_q.port}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_addr   = ram_rdata[EW-1:PORT_BITS];
  assign rd_port   = ram_rdata[PORT_BITS-1:0];
  assign chk_nx    = chk_q + IW'(1);
  assign slot_live = valid_q[chk_q];
  assign port_hit  = rd_port == cmd_q.port;
  assign addr_hit  = (rd_addr == '0) || (rd_addr == cmd_q.addr);
  assign eph_off   = rd_port - EPH_FIRST;
  assign eph_in    = (rd_port >= EPH_FIRST) && (eph_off <= SPAN);
  assign cand_port = EPH_FIRST + PORT_BITS'(pick_q);
  assign out_free  = !out_vld_q || rsp_o.ready;

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.status   = out_q.status;
  assign rsp_o.slot_out = out_q.slot;
  assign rsp_o.addr_out = out_q.addr;
  assign rsp_o.port_out = out_q.port;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    chk_d     = chk_q;
    pick_d    = pick_q;
    used_d    = used_q;
    valid_d   = valid_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = '0;

    case (state_q)
      BK_IDLE: begin
        if (cmd_avail_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          chk_d     = '0;
          case (cmd_i.op)
            OP_FIND: state_d = BK_FIND;
            OP_GET, OP_REMOVE: begin
              if (cmd_i.idx_ok && valid_q[IW'(cmd_i.idx)]) begin
                ram_raddr = IW'(cmd_i.idx);
                chk_d     = IW'(cmd_i.idx);
                state_d   = BK_READ;
              end else begin
                res_d   = RES_MISS;
                state_d = BK_EMIT;
              end
            end
            OP_ADD: state_d = BK_ADD;
            OP_ALLOC: begin
              used_d  = '0;
              state_d = BK_MAP;
            end
            default: begin
              res_d   = RES_MISS;
              state_d = BK_EMIT;
            end
          endcase
        end
      end

      BK_READ: begin
        res_d = '{status: ST_OK, slot: SLOT_BITS'(chk_q), addr: rd_addr, port: rd_port};
        if (cmd_q.op == OP_REMOVE) begin
          valid_d[chk_q] = 1'b0;
        end
        state_d = BK_EMIT;
      end

      BK_FIND: begin
        if (slot_live && port_hit && addr_hit) begin
          res_d = '{status: ST_OK, slot: SLOT_BITS'(chk_q), addr: rd_addr, port: rd_port};
          state_d = BK_EMIT;
        end else if (chk_q == LAST) begin
          res_d   = RES_MISS;
          state_d = BK_EMIT;
        end else begin
          chk_d     = chk_nx;
          ram_raddr = chk_nx;
        end
      end

      BK_ADD: begin
        if (!slot_live) begin
          ram_we         = 1'b1;
          valid_d[chk_q] = 1'b1;
          res_d = '{status: ST_OK, slot: SLOT_BITS'(chk_q), addr: cmd_q.addr,
                    port: cmd_q.port};
          state_d = BK_EMIT;
        end else if (chk_q == LAST) begin
          res_d   = RES_FULL;
          state_d = BK_EMIT;
        end else begin
          chk_d = chk_nx;
        end
      end

      BK_MAP: begin
        if (slot_live && eph_in) begin
          used_d[CW'(eph_off)] = 1'b1;
        end
        if (chk_q == LAST) begin
          pick_d  = '0;
          state_d = BK_PICK;
        end else begin
          chk_d     = chk_nx;
          ram_raddr = chk_nx;
        end
      end

      BK_PICK: begin
        if (!used_q[0]) begin
          if (cand_port == EPH_NONE) begin
            res_d = '{status: ST_NOPORT, slot: '0, addr: '0, port: EPH_NONE};
          end else begin
            res_d = '{status: ST_OK, slot: '0, addr: '0, port: cand_port};
          end
          state_d = BK_EMIT;
        end else begin
          used_d = used_q >> 1;
          pick_d = pick_q + CW'(1);
        end
      end

      BK_EMIT: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = BK_IDLE;
        end
      end

      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    chk_q  <= chk_d;
    pick_q <= pick_d;
    used_q <= used_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule
